FILE: rtl/fnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fnp_pkg;

   // fixed field widths
   localparam int CH_W    = 8;
   localparam int CNT_W   = 8;
   localparam int BASE_W  = 6;
   localparam int VALUE_W = 64;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 2;

   // register map
   localparam logic [ADDR_W-1:0] ADDR_DEFAULT_BASE = 2'd0;
   localparam logic [BASE_W-1:0] DEFAULT_BASE_RESET = 6'd10;

   // character codes
   localparam logic [CH_W-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [CH_W-1:0] CH_HASH    = 8'h23;
   localparam logic [CH_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CH_W-1:0] CH_QUOTE   = 8'h27;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;
   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5a;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7a;
   localparam logic [CH_W-1:0] LETTER_OFFSET = 8'd10;

   // prefix radixes
   localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
   localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
   localparam logic [BASE_W-1:0] BASE_BIN = 6'd2;

   // quoted literal: quote, character, closing quote
   localparam logic [CNT_W-1:0] QUOTE_LEN = 8'd3;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value_low;
      logic [VALUE_W-1:0] value_high;
      logic [CNT_W-1:0]   unconverted;
      logic               ok;
   } rsp_type;

   typedef struct packed {
      logic              is_digit;
      logic [BASE_W-1:0] digit;
      logic              is_minus;
      logic              is_quote;
      logic              is_prefix;
      logic [BASE_W-1:0] prefix_base;
   } char_class_type;

endpackage

`default_nettype wire

FILE: rtl/fnp_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// Classify one character: digit value, sign, quote and radix prefix.
module fnp_decode (
   input  wire logic [fnp_pkg::CH_W-1:0] ch,
   output fnp_pkg::char_class_type       cls
);

   always_comb begin
      cls = '0;
      if (ch >= fnp_pkg::CH_ZERO && ch <= fnp_pkg::CH_NINE) begin
         cls.is_digit = 1'b1;
         cls.digit    = fnp_pkg::BASE_W'(ch - fnp_pkg::CH_ZERO);
      end else if (ch >= fnp_pkg::CH_UPPER_A && ch <= fnp_pkg::CH_UPPER_Z) begin
         cls.is_digit = 1'b1;
         cls.digit    = fnp_pkg::BASE_W'(ch - fnp_pkg::CH_UPPER_A + fnp_pkg::LETTER_OFFSET);
      end else if (ch >= fnp_pkg::CH_LOWER_A && ch <= fnp_pkg::CH_LOWER_Z) begin
         cls.is_digit = 1'b1;
         cls.digit    = fnp_pkg::BASE_W'(ch - fnp_pkg::CH_LOWER_A + fnp_pkg::LETTER_OFFSET);
      end

      cls.is_minus = (ch == fnp_pkg::CH_MINUS);
      cls.is_quote = (ch == fnp_pkg::CH_QUOTE);

      case (ch)
         fnp_pkg::CH_DOLLAR: begin
            cls.is_prefix   = 1'b1;
            cls.prefix_base = fnp_pkg::BASE_HEX;
         end
         fnp_pkg::CH_HASH: begin
            cls.is_prefix   = 1'b1;
            cls.prefix_base = fnp_pkg::BASE_DEC;
         end
         fnp_pkg::CH_PERCENT: begin
            cls.is_prefix   = 1'b1;
            cls.prefix_base = fnp_pkg::BASE_BIN;
         end
         default: begin
            cls.is_prefix   = 1'b0;
            cls.prefix_base = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/fnp_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Double-cell multiply by radix and add (or subtract) one digit, modulo 2^(2*CELL_BITS).
module fnp_mac #(
   parameter int CELL_BITS = 64
) (
   input  wire logic [2*CELL_BITS-1:0]     acc,
   input  wire logic [fnp_pkg::BASE_W-1:0] base,
   input  wire logic [fnp_pkg::BASE_W-1:0] digit,
   input  wire logic                       negate,
   output logic      [2*CELL_BITS-1:0]     sum
);

   localparam int ACC_W = 2 * CELL_BITS;

   logic [ACC_W-1:0] prod;
   logic [ACC_W-1:0] digit_ext;
   logic [ACC_W-1:0] addend;

   // narrow operand: six partial products
   assign prod      = acc * ACC_W'(base);
   assign digit_ext = ACC_W'(digit);
   // a negative number is built negative digit by digit
   assign addend    = negate ? (~digit_ext + ACC_W'(1)) : digit_ext;
   assign sum       = prod + addend;

endmodule

`default_nettype wire

FILE: rtl/forth_number_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  fnp_pkg::req_type  (ch, last)
// rsp       out        rsp_valid / rsp_stall  fnp_pkg::rsp_type  (value, unconverted, ok)
// csr       in/out     APB psel/penable       default_base at byte address 0
//
// One character per cycle, sustained. A request lands in the input register, then
// decode plus a double-cell multiply-by-radix-and-add updates the token state; the final
// character of a token also loads the result register, so its result passes the input
// and result registers in turn. The multiply-add loop on the accumulator sets the pace.
// Reset is synchronous and clears all control state; default_base returns to ten.
// A stalled result only holds back a final character; other characters keep flowing.
module forth_number_parser #(
   parameter int CELL_BITS = 64,
   parameter int MAX_TOKEN = 255
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire fnp_pkg::req_type            req_data,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output fnp_pkg::rsp_type                 rsp_data,

   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [fnp_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [fnp_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [fnp_pkg::CSR_W-1:0]        csr_prdata,
   output logic                             csr_pready
);

   localparam int ACC_W = 2 * CELL_BITS;
   localparam logic [fnp_pkg::CNT_W-1:0] MAX_T = fnp_pkg::CNT_W'(MAX_TOKEN);

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [fnp_pkg::BASE_W-1:0] default_base_ff;
   logic [fnp_pkg::BASE_W-1:0] default_base_in;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      default_base_in = default_base_ff;
      if (csr_write && csr_paddr == fnp_pkg::ADDR_DEFAULT_BASE) begin
         default_base_in = csr_pwdata[fnp_pkg::BASE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == fnp_pkg::ADDR_DEFAULT_BASE) ?
                       fnp_pkg::CSR_W'(default_base_ff) : '0;

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic             in_valid_ff;
   logic             in_valid_in;
   fnp_pkg::req_type in_data_ff;
   fnp_pkg::req_type in_data_in;
   logic             advance;

   // a final character waits only while an earlier result is still held
   assign advance   = in_valid_ff && !(in_data_ff.last && rsp_valid && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_data_in = req_data;
         end
      end
   end

   // ------------------------------------------------------------------
   // Token state
   // ------------------------------------------------------------------
   logic [ACC_W-1:0]           acc_ff,       acc_in;
   logic [fnp_pkg::CNT_W-1:0]  char_idx_ff,  char_idx_in;
   logic [fnp_pkg::BASE_W-1:0] base_ff,      base_in;
   logic                       minus_ff,     minus_in;
   logic                       halted_ff,    halted_in;
   logic [fnp_pkg::CNT_W-1:0]  left_ff,      left_in;
   logic                       quote_ff,     quote_in;
   logic [fnp_pkg::CH_W-1:0]   quoted_ff,    quoted_in;
   logic                       sign_open_ff, sign_open_in;

   fnp_pkg::char_class_type cls;
   logic [ACC_W-1:0]        mac_sum;

   // values in force for this character, after the start-of-token reload
   logic                       first;
   logic [ACC_W-1:0]           cur_acc;
   logic [fnp_pkg::BASE_W-1:0] cur_base;
   logic                       cur_minus;
   logic                       cur_halted;
   logic [fnp_pkg::CNT_W-1:0]  cur_left;
   logic                       cur_quote;
   logic                       cur_sign_open;
   logic                       digit_ok;
   logic [fnp_pkg::CNT_W-1:0]  len;

   fnp_decode u_decode (
      .ch  (in_data_ff.ch),
      .cls (cls)
   );

   fnp_mac #(
      .CELL_BITS (CELL_BITS)
   ) u_mac (
      .acc    (cur_acc),
      .base   (cur_base),
      .digit  (cls.digit),
      .negate (cur_minus),
      .sum    (mac_sum)
   );

   always_comb begin
      first         = (char_idx_ff == '0);
      cur_acc       = first ? '0 : acc_ff;
      cur_base      = first ? default_base_ff : base_ff;
      cur_minus     = first ? 1'b0 : minus_ff;
      cur_halted    = first ? 1'b0 : halted_ff;
      cur_left      = first ? '0 : left_ff;
      cur_quote     = first ? 1'b0 : quote_ff;
      cur_sign_open = first ? 1'b1 : sign_open_ff;
      digit_ok      = cls.is_digit && (cls.digit < cur_base);
      // saturating character count including this one
      len           = (char_idx_ff >= MAX_T) ? MAX_T : char_idx_ff + 1'b1;

      acc_in       = cur_acc;
      base_in      = cur_base;
      minus_in     = cur_minus;
      halted_in    = cur_halted;
      left_in      = cur_left;
      quote_in     = cur_quote;
      quoted_in    = quoted_ff;
      sign_open_in = cur_sign_open;

      if (first && cls.is_prefix) begin
         // radix prefix; a minus may still follow
         base_in      = cls.prefix_base;
         sign_open_in = 1'b1;
      end else if (first && cls.is_quote) begin
         quote_in     = 1'b1;
         sign_open_in = 1'b0;
      end else if (cur_quote) begin
         if (char_idx_ff == fnp_pkg::CNT_W'(1)) begin
            quoted_in = in_data_ff.ch;
         end
      end else begin
         sign_open_in = 1'b0;
         if (cur_sign_open && cls.is_minus) begin
            minus_in = 1'b1;
         end else if (cur_halted) begin
            // count everything after the character that stopped conversion
            left_in = (cur_left >= MAX_T) ? MAX_T : cur_left + 1'b1;
         end else if (!digit_ok) begin
            halted_in = 1'b1;
            left_in   = fnp_pkg::CNT_W'(1);
         end else begin
            acc_in = mac_sum;
         end
      end

      char_idx_in = in_data_ff.last ? '0 : len;
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic             rsp_valid_ff, rsp_valid_in;
   fnp_pkg::rsp_type rsp_data_ff,  rsp_data_in;
   logic [CELL_BITS-1:0] quote_cell;

   assign quote_cell = {{(CELL_BITS - fnp_pkg::CH_W){quoted_in[fnp_pkg::CH_W-1]}}, quoted_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (advance && in_data_ff.last) begin
         rsp_valid_in = 1'b1;
         if (quote_in) begin
            if (len < fnp_pkg::QUOTE_LEN) begin
               // quoted token too short to hold a character
               rsp_data_in.value_low   = '0;
               rsp_data_in.value_high  = '0;
               rsp_data_in.unconverted = fnp_pkg::CNT_W'(1);
               rsp_data_in.ok          = 1'b0;
            end else begin
               rsp_data_in.value_low   = fnp_pkg::VALUE_W'(quote_cell);
               rsp_data_in.value_high  = '0;
               rsp_data_in.unconverted = len - fnp_pkg::QUOTE_LEN;
               rsp_data_in.ok          = (len == fnp_pkg::QUOTE_LEN);
            end
         end else begin
            rsp_data_in.value_low   = fnp_pkg::VALUE_W'(acc_in[CELL_BITS-1:0]);
            rsp_data_in.value_high  = fnp_pkg::VALUE_W'(acc_in[ACC_W-1:CELL_BITS]);
            rsp_data_in.unconverted = left_in;
            rsp_data_in.ok          = (left_in == '0);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         default_base_ff <= fnp_pkg::DEFAULT_BASE_RESET;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         char_idx_ff     <= '0;
         base_ff         <= fnp_pkg::BASE_DEC;
         minus_ff        <= 1'b0;
         halted_ff       <= 1'b0;
         left_ff         <= '0;
         quote_ff        <= 1'b0;
         sign_open_ff    <= 1'b0;
      end else begin
         default_base_ff <= default_base_in;
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (advance) begin
            char_idx_ff  <= char_idx_in;
            base_ff      <= base_in;
            minus_ff     <= minus_in;
            halted_ff    <= halted_in;
            left_ff      <= left_in;
            quote_ff     <= quote_in;
            sign_open_ff <= sign_open_in;
         end
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
      if (advance) begin
         acc_ff    <= acc_in;
         quoted_ff <= quoted_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a consumed final character always produces a result and restarts the token
   a_last_makes_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.last |=> rsp_valid_ff && char_idx_ff == '0)
      else $error("final character did not produce a result");

   // the character count never passes its saturation point
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      char_idx_ff <= MAX_T)
      else $error("character count above saturation");

   // a stopped conversion always has something left unconverted
   a_halt_counts: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> left_ff != '0)
      else $error("conversion stopped with zero unconverted count");

   // ok agrees with the unconverted count
   a_ok_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.ok == (rsp_data_ff.unconverted == '0))
      else $error("ok flag disagrees with unconverted count");
`endif

endmodule

`default_nettype wire
